// ===== hdl/softmax_cross_entropy_grad_macros.svh =====
// ----------------------------------------------------------------------------
// Softmax cross-entropy gradient: assertion macros
// Shorthand for the concurrent checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef SOFTMAX_CROSS_ENTROPY_GRAD_MACROS_SVH
`define SOFTMAX_CROSS_ENTROPY_GRAD_MACROS_SVH

// A condition that must hold at every clock edge out of reset.
`define SCE_ASSERT_ALWAYS(label, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("softmax cross entropy check failed");

// A condition that must hold whenever its antecedent holds.
`define SCE_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("softmax cross entropy check failed");

`endif

// ===== hdl/sce_pkg.sv =====
// ----------------------------------------------------------------------------
// Softmax cross-entropy gradient: package
// Widths, codes, sequencer states and the Q16 lookup tables.
// ----------------------------------------------------------------------------
package sce_pkg;

  localparam int MAX_CLASSES = 32768;
  localparam int ADDR_W      = $clog2(MAX_CLASSES);
  localparam int CNT_W       = ADDR_W + 1;
  localparam int LOGIT_W     = 24;
  localparam int TGT_W       = 17;
  localparam int GRAD_W      = 18;
  localparam int PROB_W      = 17;
  localparam int LOSS_W      = 24;
  localparam int SUM_W       = 32;
  localparam int DIFF_W      = LOGIT_W + 1;
  localparam int T_W         = 26;
  localparam int NUM_W       = 34;
  localparam int DCNT_W      = 6;

  localparam logic [16:0]         LOG2E_Q16       = 17'd94548;
  localparam logic [15:0]         LN2_Q16         = 16'd45426;
  localparam logic [PROB_W-1:0]   ONE_Q16         = 17'd65536;
  localparam logic [LOSS_W-1:0]   LOSS_FLOOR      = 24'd1509022;
  localparam logic [LOSS_W-1:0]   LOSS_BAD_TARGET = 24'd1310720;
  localparam logic [LOGIT_W-1:0]  LOGIT_MIN       = 24'h800000;

  typedef enum logic {CMD_LOAD, CMD_READ} cmd_t;
  typedef enum logic {KIND_LOSS, KIND_GRAD} kind_t;
  typedef enum logic [1:0] {ST_OK, ST_BAD_TARGET, ST_EMPTY, ST_OVERFLOW} status_t;

  typedef enum logic [4:0] {
    S_IDLE, S_RD_WAIT, S_RD_OUT,
    S_P1_RD, S_P1_MUL, S_P1_INT,
    S_P2_FIX, S_P2_RD, S_P2_LD, S_P2_DIV, S_P2_WR,
    S_T_CHK, S_T_RD, S_T_LD, S_T_NORM, S_T_LOG, S_T_LN, S_T_WR
  } state_t;

  // 2^(-k/16) in Q16.
  function automatic logic [16:0] pow2_neg(input logic [4:0] k);
    logic [16:0] v;
    case (k)
      5'd0:    v = 17'd65536;
      5'd1:    v = 17'd62757;
      5'd2:    v = 17'd60097;
      5'd3:    v = 17'd57549;
      5'd4:    v = 17'd55109;
      5'd5:    v = 17'd52773;
      5'd6:    v = 17'd50535;
      5'd7:    v = 17'd48393;
      5'd8:    v = 17'd46341;
      5'd9:    v = 17'd44376;
      5'd10:   v = 17'd42495;
      5'd11:   v = 17'd40693;
      5'd12:   v = 17'd38968;
      5'd13:   v = 17'd37316;
      5'd14:   v = 17'd35734;
      5'd15:   v = 17'd34219;
      default: v = 17'd32768;
    endcase
    return v;
  endfunction

  // log2(1 + k/16) in Q16.
  function automatic logic [16:0] log2_frac(input logic [4:0] k);
    logic [16:0] v;
    case (k)
      5'd0:    v = 17'd0;
      5'd1:    v = 17'd5732;
      5'd2:    v = 17'd11136;
      5'd3:    v = 17'd16248;
      5'd4:    v = 17'd21098;
      5'd5:    v = 17'd25711;
      5'd6:    v = 17'd30109;
      5'd7:    v = 17'd34312;
      5'd8:    v = 17'd38336;
      5'd9:    v = 17'd42196;
      5'd10:   v = 17'd45904;
      5'd11:   v = 17'd49472;
      5'd12:   v = 17'd52911;
      5'd13:   v = 17'd56229;
      5'd14:   v = 17'd59434;
      5'd15:   v = 17'd62534;
      default: v = 17'd65536;
    endcase
    return v;
  endfunction

endpackage

// ===== hdl/softmax_cross_entropy_grad.sv =====
// ----------------------------------------------------------------------------
// Softmax cross-entropy gradient
// Loads class logits, computes softmax, loss of the target and gradients.
// ----------------------------------------------------------------------------
// A load word is stored as it is taken; the word marked last starts the
// computation, and the block stalls its command side until the loss word is
// out. The exponent pass steps each class through read, multiply and sum
// states, the normalize pass runs the bit-serial divider on each class (one
// quotient bit a cycle), and the loss then needs a leading-one shift search.
// A read word returns one gradient through a wait state and an output state.
// A waiting result word holds off new commands, but a command is taken in the
// cycle that the result word leaves. There is no clearing pass.
`include "softmax_cross_entropy_grad_macros.svh"

module softmax_cross_entropy_grad
  import sce_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cmd_valid,
  output logic                      cmd_stall,
  input  logic                      command,
  input  logic signed [LOGIT_W-1:0] logit,
  input  logic                      last,
  input  logic signed [TGT_W-1:0]   target,
  output logic                      res_valid,
  input  logic                      res_stall,
  output logic                      kind,
  output logic [LOSS_W-1:0]         loss,
  output logic signed [GRAD_W-1:0]  gradient,
  output logic [ADDR_W-1:0]         index,
  output logic                      final_res,
  output logic [1:0]                status
);

  state_t state, state_next;

  logic [CNT_W-1:0]          count, rp, idx;
  logic signed [LOGIT_W-1:0] running_max;
  logic [SUM_W-1:0]          exp_sum;
  logic signed [TGT_W-1:0]   target_class;
  logic                      ovf, ready;
  logic [1:0]                vec_status;
  logic [T_W-1:0]            t_reg;
  logic [SUM_W-1:0]          div_rem;
  logic [NUM_W-1:0]          div_num;
  logic [DCNT_W-1:0]         div_cnt;
  logic [PROB_W-1:0]         pval, norm_m;
  logic [4:0]                norm_sh;
  logic [20:0]               lg_diff;
  logic [LOSS_W-1:0]         loss_reg;

  logic [LOGIT_W-1:0] logit_mem [MAX_CLASSES];
  logic [GRAD_W-1:0]  grad_mem  [MAX_CLASSES];
  logic [LOGIT_W-1:0] logit_rd;
  logic [GRAD_W-1:0]  grad_rd;
  logic               logit_we, grad_we;
  logic [GRAD_W-1:0]  grad_wdata;

  // Load-side view of the state: a finished vector restarts on load.
  logic                      cmd_acc, has_room, in_range, rd_empty, last_elem, empty_rd;
  logic [CNT_W-1:0]          cnt_eff;
  logic signed [LOGIT_W-1:0] max_eff;
  logic                      ovf_eff;

  assign cmd_acc   = cmd_valid && !cmd_stall;
  assign cnt_eff   = ready ? '0 : count;
  assign max_eff   = ready ? LOGIT_MIN : running_max;
  assign ovf_eff   = ready ? 1'b0 : ovf;
  assign has_room  = cnt_eff < CNT_W'(MAX_CLASSES);
  assign rd_empty  = !ready || (rp >= count);
  assign empty_rd  = cmd_acc && (command == CMD_READ) && rd_empty;
  assign in_range  = !target_class[TGT_W-1] && (target_class[CNT_W-1:0] < count);
  assign last_elem = (idx + 1'b1) == count;
  assign cmd_stall = (state != S_IDLE) || (res_valid && res_stall);

  // Exponent pass, first step: scaled distance below the maximum.
  logic [DIFF_W-1:0] p1_diff;
  logic [41:0]       p1_prod;
  assign p1_diff = {running_max[LOGIT_W-1], running_max} - {logit_rd[LOGIT_W-1], logit_rd};
  assign p1_prod = 42'(p1_diff) * 42'(LOG2E_Q16) + 42'd32768;

  // Exponent pass, second step: interpolated 2^-f shifted by the integer part.
  logic [9:0]        ip;
  logic [4:0]        ek;
  logic [16:0]       epk, epk1, ediff, ev, e_val;
  logic [23:0]       edm;
  logic [24:0]       edr;
  logic [SUM_W:0]    sum_ext;
  logic [SUM_W-1:0]  sum_sat;
  assign ip      = t_reg[T_W-1:16];
  assign ek      = {1'b0, t_reg[15:12]};
  assign epk     = pow2_neg(ek);
  assign epk1    = pow2_neg(ek + 5'd1);
  assign ediff   = epk - epk1;
  assign edm     = ediff[11:0] * t_reg[11:0];
  assign edr     = 25'(edm) + 25'd2048;
  assign ev      = epk - 17'(edr[24:12]);
  assign e_val   = (ip >= 10'd17) ? '0 : (ev >> ip[4:0]);
  assign sum_ext = {1'b0, exp_sum} + (SUM_W+1)'(e_val);
  assign sum_sat = sum_ext[SUM_W] ? '1 : sum_ext[SUM_W-1:0];

  // Normalize pass: restoring divider, one quotient bit a cycle.
  logic [NUM_W-1:0]  numer;
  logic [SUM_W:0]    rem_sh, rem_sub;
  logic              rem_ge;
  logic [PROB_W-1:0] p2_q;
  assign numer   = {1'b0, grad_rd[PROB_W-1:0], 16'b0} + NUM_W'(exp_sum >> 1);
  assign rem_sh  = {div_rem, div_num[NUM_W-1]};
  assign rem_ge  = rem_sh >= {1'b0, exp_sum};
  assign rem_sub = rem_sh - {1'b0, exp_sum};
  assign p2_q    = (div_num > NUM_W'(ONE_Q16)) ? ONE_Q16 : div_num[PROB_W-1:0];

  // Loss: interpolated log2 of the normalized probability, then times ln 2.
  logic [4:0]  lk, nn;
  logic [16:0] lf0, lf1, ldiff, lval;
  logic [24:0] ldm;
  logic [25:0] ldr;
  logic [20:0] lg, lg_c;
  logic [36:0] ln_prod;
  assign nn      = 5'd16 - norm_sh;
  assign lk      = {1'b0, norm_m[15:12]};
  assign lf0     = log2_frac(lk);
  assign lf1     = log2_frac(lk + 5'd1);
  assign ldiff   = lf1 - lf0;
  assign ldm     = ldiff[12:0] * norm_m[11:0];
  assign ldr     = 26'(ldm) + 26'd2048;
  assign lval    = lf0 + 17'(ldr[25:12]);
  assign lg      = {nn, 16'b0} + 21'(lval);
  assign lg_c    = (lg > 21'h100000) ? 21'h100000 : lg;
  assign ln_prod = 37'(lg_diff) * 37'(LN2_Q16) + 37'd32768;

  // Store write controls.
  always_comb begin
    logit_we   = cmd_acc && (command == CMD_LOAD) && has_room;
    grad_we    = 1'b0;
    grad_wdata = '0;
    case (state)
      S_P1_INT: begin
        grad_we    = 1'b1;
        grad_wdata = GRAD_W'(e_val);
      end
      S_P2_WR: begin
        grad_we    = 1'b1;
        grad_wdata = GRAD_W'(p2_q);
      end
      S_T_WR: begin
        grad_we    = 1'b1;
        grad_wdata = GRAD_W'(pval) - GRAD_W'(ONE_Q16);
      end
      default: begin
      end
    endcase
  end

  // Logit and gradient stores with registered reads.
  always_ff @(posedge clk) begin
    if (logit_we) begin
      logit_mem[cnt_eff[ADDR_W-1:0]] <= logit;
    end
    logit_rd <= logit_mem[idx[ADDR_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (grad_we) begin
      grad_mem[idx[ADDR_W-1:0]] <= grad_wdata;
    end
    grad_rd <= grad_mem[idx[ADDR_W-1:0]];
  end

  // Sequencer state register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (cmd_acc) begin
          if (command == CMD_READ) begin
            state_next = rd_empty ? S_IDLE : S_RD_WAIT;
          end else if (last) begin
            state_next = S_P1_RD;
          end
        end
      end
      S_RD_WAIT: state_next = S_RD_OUT;
      S_RD_OUT:  state_next = S_IDLE;
      S_P1_RD:   state_next = S_P1_MUL;
      S_P1_MUL:  state_next = S_P1_INT;
      S_P1_INT:  state_next = last_elem ? S_P2_FIX : S_P1_RD;
      S_P2_FIX:  state_next = S_P2_RD;
      S_P2_RD:   state_next = S_P2_LD;
      S_P2_LD:   state_next = S_P2_DIV;
      S_P2_DIV:  state_next = (div_cnt == DCNT_W'(1)) ? S_P2_WR : S_P2_DIV;
      S_P2_WR:   state_next = last_elem ? S_T_CHK : S_P2_RD;
      S_T_CHK:   state_next = in_range ? S_T_RD : S_IDLE;
      S_T_RD:    state_next = S_T_LD;
      S_T_LD:    state_next = (grad_rd[PROB_W-1:0] == '0) ? S_T_WR : S_T_NORM;
      S_T_NORM:  state_next = norm_m[PROB_W-1] ? S_T_LOG : S_T_NORM;
      S_T_LOG:   state_next = S_T_LN;
      S_T_LN:    state_next = S_T_WR;
      S_T_WR:    state_next = S_IDLE;
      default:   state_next = S_IDLE;
    endcase
  end

  // Vector state, datapath registers and the result word.
  always_ff @(posedge clk) begin
    if (rst) begin
      count        <= '0;
      rp           <= '0;
      running_max  <= LOGIT_MIN;
      exp_sum      <= '0;
      target_class <= '0;
      ovf          <= 1'b0;
      ready        <= 1'b0;
      vec_status   <= ST_OK;
      res_valid    <= 1'b0;
    end else begin
      if (res_valid && !res_stall && !empty_rd) begin
        res_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (cmd_acc && command == CMD_READ) begin
            if (rd_empty) begin
              res_valid <= 1'b1;
              kind      <= KIND_GRAD;
              loss      <= '0;
              gradient  <= '0;
              index     <= '0;
              final_res <= 1'b0;
              status    <= ST_EMPTY;
            end else begin
              idx <= rp;
            end
          end else if (cmd_acc) begin
            count <= has_room ? cnt_eff + 1'b1 : cnt_eff;
            running_max <= (has_room && logit > max_eff) ? logit : max_eff;
            ovf   <= ovf_eff || !has_room;
            ready <= 1'b0;
            if (ready) begin
              rp <= '0;
            end
            if (last) begin
              target_class <= target;
              exp_sum      <= '0;
              idx          <= '0;
            end
          end
        end
        S_RD_OUT: begin
          res_valid <= 1'b1;
          kind      <= KIND_GRAD;
          loss      <= '0;
          gradient  <= grad_rd;
          index     <= rp[ADDR_W-1:0];
          final_res <= (rp + 1'b1) == count;
          status    <= vec_status;
          rp        <= rp + 1'b1;
        end
        S_P1_MUL: begin
          t_reg <= p1_prod[41:16];
        end
        S_P1_INT: begin
          exp_sum <= sum_sat;
          idx     <= last_elem ? '0 : idx + 1'b1;
        end
        S_P2_FIX: begin
          if (exp_sum == '0) begin
            exp_sum <= SUM_W'(1);
          end
        end
        S_P2_LD: begin
          div_num <= numer;
          div_rem <= '0;
          div_cnt <= DCNT_W'(NUM_W);
        end
        S_P2_DIV: begin
          div_rem <= rem_ge ? rem_sub[SUM_W-1:0] : rem_sh[SUM_W-1:0];
          div_num <= {div_num[NUM_W-2:0], rem_ge};
          div_cnt <= div_cnt - 1'b1;
        end
        S_P2_WR: begin
          idx <= idx + 1'b1;
        end
        S_T_CHK: begin
          if (in_range) begin
            idx <= target_class[CNT_W-1:0];
          end else begin
            res_valid  <= 1'b1;
            kind       <= KIND_LOSS;
            loss       <= LOSS_BAD_TARGET;
            gradient   <= '0;
            index      <= '0;
            final_res  <= 1'b0;
            status     <= ovf ? ST_OVERFLOW : ST_BAD_TARGET;
            vec_status <= ovf ? ST_OVERFLOW : ST_BAD_TARGET;
            ready      <= 1'b1;
            rp         <= '0;
          end
        end
        S_T_LD: begin
          pval     <= grad_rd[PROB_W-1:0];
          norm_m   <= grad_rd[PROB_W-1:0];
          norm_sh  <= '0;
          loss_reg <= LOSS_FLOOR;
        end
        S_T_NORM: begin
          if (!norm_m[PROB_W-1]) begin
            norm_m  <= {norm_m[PROB_W-2:0], 1'b0};
            norm_sh <= norm_sh + 1'b1;
          end
        end
        S_T_LOG: begin
          lg_diff <= 21'h100000 - lg_c;
        end
        S_T_LN: begin
          loss_reg <= LOSS_W'(ln_prod[36:16]);
        end
        S_T_WR: begin
          res_valid  <= 1'b1;
          kind       <= KIND_LOSS;
          loss       <= loss_reg;
          gradient   <= '0;
          index      <= '0;
          final_res  <= 1'b0;
          status     <= ovf ? ST_OVERFLOW : ST_OK;
          vec_status <= ovf ? ST_OVERFLOW : ST_OK;
          ready      <= 1'b1;
          rp         <= '0;
        end
        default: begin
        end
      endcase
    end
  end

  // Checks on the sequencer, the class count and the divider.
  `SCE_ASSERT_IMP(a_accept_idle, cmd_valid && !cmd_stall, state == S_IDLE && !(res_valid && res_stall))
  `SCE_ASSERT_ALWAYS(a_count_bound, count <= CNT_W'(MAX_CLASSES))
  `SCE_ASSERT_IMP(a_div_rem, state == S_P2_DIV, div_rem < exp_sum)

endmodule

// ===== verif/softmax_cross_entropy_grad_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Softmax cross-entropy gradient: testbench
// Feeds logit vectors and gradient reads, predicts every loss and gradient
// word in fixed point, and compares each output word with the prediction.
// ----------------------------------------------------------------------------
module softmax_cross_entropy_grad_test;
  import sce_pkg::*;

  typedef enum logic [1:0] {OP_WORD, OP_DRAIN, OP_HOLD} op_t;

  typedef struct {
    op_t                      op;
    int                       phase;
    cmd_t                     cmd;
    logic signed [LOGIT_W-1:0] lg;
    logic                     lst;
    logic signed [TGT_W-1:0]  tg;
  } cmd_word_t;

  typedef struct {
    kind_t                    kd;
    logic [LOSS_W-1:0]        ls;
    logic [GRAD_W-1:0]        gr;
    logic [ADDR_W-1:0]        ix;
    logic                     fin;
    logic [1:0]               st;
  } out_word_t;

  localparam int HOLD_CYCLES = 400;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cmd_valid = 1'b0;
  logic cmd_stall;
  logic command = CMD_LOAD;
  logic signed [LOGIT_W-1:0] logit = '0;
  logic last = 1'b0;
  logic signed [TGT_W-1:0] target = '0;
  logic res_valid;
  logic res_stall = 1'b1;
  logic kind;
  logic [LOSS_W-1:0] loss;
  logic signed [GRAD_W-1:0] gradient;
  logic [ADDR_W-1:0] index;
  logic final_res;
  logic [1:0] status;

  softmax_cross_entropy_grad dut (.*);

  always #1 clk = ~clk;

  cmd_word_t pending[$];
  out_word_t expected[$];
  int gen_phase = 0;
  int tx_phase = 0;
  int hold_seq = 0;
  int mismatches = 0;

  // Shadow state of the engine.
  logic signed [LOGIT_W-1:0] logit_mem[MAX_CLASSES];
  int                        prob_mem[MAX_CLASSES];
  int unsigned               n_classes = 0;
  int unsigned               read_ptr = 0;
  logic signed [LOGIT_W-1:0] vec_max = LOGIT_MIN;
  bit                        vec_overflow = 0;
  bit                        vec_ready = 0;
  logic [1:0]                vec_status = ST_OK;

  // e^(-a) in Q16 for a nonnegative Q16 distance.
  function automatic longint unsigned exp_q16(longint unsigned a);
    longint unsigned t, ip, v;
    int k, r, pk, pk1;
    t = (a * 94548 + 32768) >> 16;
    ip = t >> 16;
    k = int'((t & 16'hFFFF) >> 12);
    r = int'(t & 12'hFFF);
    if (ip >= 17) return 0;
    pk = int'(pow2_neg(5'(k)));
    pk1 = int'(pow2_neg(5'(k + 1)));
    v = longint'(pk - (((pk - pk1) * r + 2048) >> 12));
    return v >> ip;
  endfunction

  // -ln(p / 65536) in Q16 for p in 1..65536.
  function automatic longint unsigned neg_log_q16(longint unsigned p);
    longint unsigned m, f, lg;
    int n, k, r, l0, l1;
    n = 0;
    while (n < 16 && (p >> (n + 1)) != 0) n++;
    m = p << (16 - n);
    f = (m - 65536) & 16'hFFFF;
    k = int'(f >> 12);
    r = int'(f & 12'hFFF);
    l0 = int'(log2_frac(5'(k)));
    l1 = int'(log2_frac(5'(k + 1)));
    lg = longint'(n * 65536 + l0 + (((l1 - l0) * r + 2048) >> 12));
    if (lg > 16 * 65536) lg = 16 * 65536;
    return ((16 * 65536 - lg) * 45426 + 32768) >> 16;
  endfunction

  // Softmax over the held logits; returns the loss of the target class.
  function automatic logic [LOSS_W-1:0] softmax_loss(int tgt);
    longint unsigned sum, e, p;
    logic [LOSS_W-1:0] lv;
    bit in_range;
    sum = 0;
    for (int i = 0; i < n_classes; i++) begin
      e = exp_q16(longint'(vec_max) - longint'(logit_mem[i]));
      prob_mem[i] = int'(e);
      sum += e;
      if (sum > 64'hFFFFFFFF) sum = 64'hFFFFFFFF;
    end
    if (sum == 0) sum = 1;
    for (int i = 0; i < n_classes; i++) begin
      p = (longint'(prob_mem[i]) * 65536 + sum / 2) / sum;
      if (p > 65536) p = 65536;
      prob_mem[i] = int'(p);
    end
    in_range = tgt >= 0 && tgt < n_classes;
    if (in_range) begin
      lv = (prob_mem[tgt] == 0) ? LOSS_FLOOR : LOSS_W'(neg_log_q16(prob_mem[tgt]));
      prob_mem[tgt] -= 65536;
    end else begin
      lv = LOSS_BAD_TARGET;
    end
    vec_status = vec_overflow ? ST_OVERFLOW : (in_range ? ST_OK : ST_BAD_TARGET);
    read_ptr = 0;
    vec_ready = 1;
    return lv;
  endfunction

  // Updates the shadow state for one accepted command word.
  function automatic void predict_word(cmd_t c, logic signed [LOGIT_W-1:0] lg,
                                       logic lst, logic signed [TGT_W-1:0] tg);
    out_word_t o;
    o = '{KIND_LOSS, '0, '0, '0, 1'b0, ST_OK};
    if (c == CMD_LOAD) begin
      if (vec_ready) begin
        n_classes = 0;
        read_ptr = 0;
        vec_max = LOGIT_MIN;
        vec_overflow = 0;
        vec_ready = 0;
      end
      if (n_classes < MAX_CLASSES) begin
        logit_mem[n_classes] = lg;
        n_classes++;
        if (lg > vec_max) vec_max = lg;
      end else begin
        vec_overflow = 1;
      end
      if (!lst) return;
      o.ls = softmax_loss(int'(tg));
      o.st = vec_status;
    end else begin
      o.kd = KIND_GRAD;
      if (!vec_ready || read_ptr >= n_classes) begin
        o.st = ST_EMPTY;
      end else begin
        o.gr = GRAD_W'(prob_mem[read_ptr]);
        o.ix = ADDR_W'(read_ptr);
        o.fin = (read_ptr + 1 == n_classes);
        o.st = vec_status;
        read_ptr++;
      end
    end
    expected.push_back(o);
  endfunction

  function automatic void push_word(cmd_t c, logic signed [LOGIT_W-1:0] lg, logic lst,
                                    logic signed [TGT_W-1:0] tg);
    pending.push_back('{OP_WORD, gen_phase, c, lg, lst, tg});
  endfunction

  function automatic void push_marker(op_t op);
    pending.push_back('{op, gen_phase, CMD_LOAD, '0, 1'b0, '0});
  endfunction

  function automatic void push_reads(int n);
    for (int i = 0; i < n; i++)
      push_word(CMD_READ, LOGIT_W'($urandom), 1'($urandom_range(0, 1)), TGT_W'($urandom));
  endfunction

  // A vector of n logits; a zero spread gives fully random logits.
  function automatic void push_vector(int n, int tgt, int spread);
    logic signed [LOGIT_W-1:0] base, v;
    base = LOGIT_W'($urandom);
    for (int i = 0; i < n; i++) begin
      v = (spread == 0) ? LOGIT_W'($urandom) : base + LOGIT_W'($urandom_range(0, spread));
      push_word(CMD_LOAD, v, i == n - 1, (i == n - 1) ? TGT_W'(tgt) : TGT_W'($urandom));
    end
  endfunction

  // Command driver.
  always @(posedge clk) begin
    cmd_word_t w;
    int idle_pct;
    if (rst) begin
      cmd_valid <= 1'b0;
    end else begin
      if (cmd_valid && !cmd_stall) predict_word(cmd_t'(command), logit, last, target);
      if (!cmd_valid || !cmd_stall) begin
        while (pending.size() > 0 && pending[0].op == OP_HOLD) begin
          hold_seq++;
          void'(pending.pop_front());
        end
        if (pending.size() > 0 && pending[0].op == OP_DRAIN && expected.size() == 0)
          void'(pending.pop_front());
        if (pending.size() > 0 && pending[0].op == OP_WORD) begin
          w = pending[0];
          idle_pct = (w.phase == 0) ? 8 : (w.phase == 1) ? 51 : 0;
          tx_phase <= w.phase;
          if ($urandom_range(0, 99) < idle_pct) begin
            cmd_valid <= 1'b0;
          end else begin
            void'(pending.pop_front());
            cmd_valid <= 1'b1;
            command <= w.cmd;
            logit <= w.lg;
            last <= w.lst;
            target <= w.tg;
          end
        end else begin
          cmd_valid <= 1'b0;
        end
      end
    end
  end

  // Result stall: random per phase, plus long hold-offs on request.
  always @(posedge clk) begin
    int hold_left;
    int hold_seen;
    int stall_pct;
    if (rst) begin
      res_stall <= 1'b1;
      hold_left = 0;
      hold_seen = 0;
    end else begin
      if (hold_seen != hold_seq) begin
        hold_seen = hold_seq;
        hold_left = HOLD_CYCLES;
      end
      stall_pct = (tx_phase == 0) ? 51 : (tx_phase == 1) ? 8 : 0;
      if (hold_left > 0) begin
        hold_left--;
        res_stall <= 1'b1;
      end else begin
        res_stall <= ($urandom_range(0, 99) < stall_pct);
      end
    end
  end

  // Result monitor: each word against the oldest prediction.
  always @(posedge clk) begin
    out_word_t e;
    if (!rst && res_valid && !res_stall) begin
      if (expected.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result word: kind %0d status %0d",
                                       kind, status);
      end else begin
        e = expected.pop_front();
        if (kind !== e.kd || loss !== e.ls || gradient !== e.gr || index !== e.ix ||
            final_res !== e.fin || status !== e.st) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected kind %0d loss %0d grad %0d idx %0d fin %0d st %0d,",
                     e.kd, e.ls, $signed(e.gr), e.ix, e.fin, e.st,
                     " got kind %0d loss %0d grad %0d idx %0d fin %0d st %0d",
                     kind, loss, gradient, index, final_res, status);
        end
      end
    end
  end

  // Stimulus and end of run.
  initial begin
    int n;
    // Directed: reads with nothing loaded, tiny vectors, extremes and bad targets.
    push_reads(2);
    push_vector(1, 0, 0);
    push_reads(2);
    push_word(CMD_LOAD, 24'sh7FFFFF, 1'b0, '0);
    push_word(CMD_LOAD, 24'sh800000, 1'b1, 17'sd1);
    push_reads(3);
    push_vector(3, -1, 16);
    push_reads(1);
    push_vector(2, 2, 0);
    push_reads(2);
    push_vector(2, -65536, 0);
    push_vector(2, 65535, 0);
    push_word(CMD_LOAD, '0, 1'b0, '0);
    push_word(CMD_LOAD, '0, 1'b1, 17'sd1);
    push_reads(3);
    push_marker(OP_DRAIN);
    // Random vectors across the three idle phases.
    for (int ph = 0; ph < 3; ph++) begin
      gen_phase = ph;
      for (int v = 0; v < 26; v++) begin
        n = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 64) : $urandom_range(1, 10);
        case ($urandom_range(0, 9))
          0: push_reads($urandom_range(1, 3));
          1: push_vector(n, $urandom, 0);
          2: push_vector(n, $urandom_range(0, n - 1), 0);
          default: push_vector(n, $urandom_range(0, n - 1), $urandom_range(1, 500000));
        endcase
        if (v == 10) push_marker(OP_HOLD);
        push_reads((v % 4 == 0) ? $urandom_range(0, n) : n + $urandom_range(0, 2));
        if (v == 20) push_marker(OP_DRAIN);
      end
    end
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    do @(posedge clk);
    while (pending.size() != 0 || cmd_valid || expected.size() != 0);
    repeat (200) @(posedge clk);
    if (mismatches == 0 && expected.size() == 0) begin
      $display("PASS softmax_cross_entropy_grad");
    end else begin
      $display("FAIL softmax_cross_entropy_grad");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #80000000;
    $display("FAIL softmax_cross_entropy_grad");
    $finish;
  end

endmodule
